@@ rtl/ogds_pkg.sv @@
// ----------------------------------------------------------------------------
// ogds_pkg
// Shared types and codes for the occupancy grid disk stamp unit.
// ----------------------------------------------------------------------------
package ogds_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_CELL_SIZE = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_ACT_W     = 3'd4,
        REG_ACT_H     = 3'd5,
        REG_OBSTACLE  = 3'd6,
        REG_FILL      = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        DIV_X = 2'd0,
        DIV_Y = 2'd1,
        DIV_R = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_USED,
        S_CLEAR,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_DIV,
        S_SQ_R,
        S_CLIP,
        S_SQ_X,
        S_SQ_Y,
        S_BASE,
        S_WALK,
        S_DONE
    } t_state;

    // restoring divider: 16 quotient bits, one per cycle, then a fixup step
    localparam logic [4:0] DIV_STEP_LAST = 5'd16;

    localparam logic [15:0] RST_ORIGIN    = 16'hE890;  // -6000 mm
    localparam logic [9:0]  RST_CELL_SIZE = 10'd100;
    localparam logic [10:0] RST_RADIUS    = 11'd300;
    localparam logic [7:0]  RST_ACT_DIM   = 8'd120;
    localparam logic [7:0]  RST_OBSTACLE  = 8'd100;
    localparam logic [7:0]  RST_FILL      = 8'd0;

endpackage

@@ rtl/occupancy_grid_disk_stamp_unit.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_disk_stamp_unit
// Occupancy grid of signed byte cells with clear, disk mark and cell read.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives one result. A clear writes one
// cell per cycle over the active_width*active_height cells. A read uses one
// memory read port with registered data. A mark runs three passes of one shared
// restoring divider (cell x, cell y, radius in cells), then squares the radius
// on one shared 12x12 multiplier, clips the window, squares the corner offsets,
// forms the row base and walks the clipped (2R+1)x(2R+1) window one cell per
// cycle. The grid has no reset; cells read
// before any write hold unknown data. Results sit in an output register, so a
// new request is taken while the previous result is still waiting.
module occupancy_grid_disk_stamp_unit #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // x_mm[15:0], y_mm[31:16], cell_index[45:32]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // cell_value[7:0], cells_written[22:8]
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    // configuration
    logic [15:0] r_org_x, r_org_y;
    logic [9:0]  r_cell;
    logic [10:0] r_rad;
    logic [7:0]  r_aw, r_ah, r_obst, r_fill;

    // control
    ogds_pkg::t_state   r_state, n_state;
    ogds_pkg::t_op      r_op, n_op;
    ogds_pkg::t_div_sel r_div_sel, n_div_sel;
    logic [4:0]  r_step, n_step;
    logic        r_out_valid, n_out_valid;

    // datapath
    logic [23:0]        r_out_data, n_out_data;
    logic signed [15:0] r_y, n_y;
    logic [13:0]        r_idx, n_idx;
    logic [15:0]        r_num, n_num;
    logic [9:0]         r_rem, n_rem;
    logic               r_neg, n_neg;
    logic signed [17:0] r_cx, n_cx, r_cy, n_cy;
    logic [11:0]        r_r, n_r;
    logic [21:0]        r_r2, n_r2;
    logic [7:0]         r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic [7:0]         r_gx, n_gx, r_gy, n_gy;
    logic signed [11:0] r_dx0, n_dx0, r_dx, n_dx, r_dy, n_dy;
    logic [21:0]        r_dx0sq, n_dx0sq, r_dx2, n_dx2, r_dy2, n_dy2;
    logic [15:0]        r_row_base, n_row_base;
    logic [14:0]        r_cnt, n_cnt;
    logic [15:0]        r_used, n_used;
    logic [15:0]        r_ptr, n_ptr;
    logic [7:0]         r_res_val, n_res_val;
    logic [7:0]         r_mem_q;

    // grid memory
    logic [7:0]    mem [CELLS];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    // effective settings
    logic [9:0] cs_eff;
    logic [7:0] w_eff, h_eff;

    assign cs_eff = (r_cell == 10'd0) ? 10'd1 : r_cell;
    assign w_eff  = ({3'b0, r_aw} > 11'(GRID_WIDTH))  ? 8'(GRID_WIDTH)  : r_aw;
    assign h_eff  = ({3'b0, r_ah} > 11'(GRID_HEIGHT)) ? 8'(GRID_HEIGHT) : r_ah;

    // shared multiplier
    logic signed [11:0] mul_a, mul_b;
    logic signed [23:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // divider step
    logic [10:0] div_trial;
    logic        div_ge;
    logic [9:0]  div_rem_next;
    assign div_trial    = {r_rem, r_num[15]};
    assign div_ge       = div_trial >= {1'b0, cs_eff};
    assign div_rem_next = div_ge ? 10'(div_trial - {1'b0, cs_eff}) : div_trial[9:0];

    // division operands
    logic signed [16:0] diff_x, diff_y;
    logic [17:0]        q_adj;
    logic signed [17:0] q_signed;
    logic [11:0]        ceil_num;
    assign diff_x   = $signed({i_s_axis_tdata[15], i_s_axis_tdata[15:0]})
                    - $signed({r_org_x[15], r_org_x});
    assign diff_y   = $signed({r_y[15], r_y}) - $signed({r_org_y[15], r_org_y});
    assign q_adj    = {2'b0, r_num} + {17'b0, (r_rem != 10'd0)};
    assign q_signed = r_neg ? -$signed(q_adj) : $signed({2'b0, r_num});
    assign ceil_num = {1'b0, r_rad} + {2'b0, cs_eff} - 12'd1;

    // window clip
    logic signed [18:0] cx19, cy19, r19, wm1, hm1;
    logic signed [18:0] x_lo, x_hi, y_lo, y_hi, x0c, x1c, y0c, y1c;
    logic signed [18:0] dx0_full, dy0_full;
    logic               clip_empty;
    assign cx19     = {r_cx[17], r_cx};
    assign cy19     = {r_cy[17], r_cy};
    assign r19      = $signed({7'b0, r_r});
    assign wm1      = $signed({11'b0, w_eff}) - 19'sd1;
    assign hm1      = $signed({11'b0, h_eff}) - 19'sd1;
    assign x_lo     = cx19 - r19;
    assign x_hi     = cx19 + r19;
    assign y_lo     = cy19 - r19;
    assign y_hi     = cy19 + r19;
    assign x0c      = (x_lo < 19'sd0) ? 19'sd0 : x_lo;
    assign x1c      = (x_hi > wm1) ? wm1 : x_hi;
    assign y0c      = (y_lo < 19'sd0) ? 19'sd0 : y_lo;
    assign y1c      = (y_hi > hm1) ? hm1 : y_hi;
    assign dx0_full = x0c - cx19;
    assign dy0_full = y0c - cy19;
    assign clip_empty = (x0c > x1c) || (y0c > y1c);

    // walk
    logic [22:0]        dist2;
    logic signed [23:0] dx2_step, dy2_step;
    logic [16:0]        walk_addr;
    assign dist2     = {1'b0, r_dx2} + {1'b0, r_dy2};
    // (d+1)^2 = d^2 + 2d + 1
    assign dx2_step  = $signed({2'b0, r_dx2}) + $signed({{11{r_dx[11]}}, r_dx, 1'b1});
    assign dy2_step  = $signed({2'b0, r_dy2}) + $signed({{11{r_dy[11]}}, r_dy, 1'b1});
    assign walk_addr = {1'b0, r_row_base} + {9'b0, r_gx};

    assign o_s_axis_tready = (r_state == ogds_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_pready        = 1'b1;

    always_comb begin
        unique case (ogds_pkg::t_reg'(i_paddr[4:2]))
            ogds_pkg::REG_ORIGIN_X:  o_prdata = {16'b0, r_org_x};
            ogds_pkg::REG_ORIGIN_Y:  o_prdata = {16'b0, r_org_y};
            ogds_pkg::REG_CELL_SIZE: o_prdata = {22'b0, r_cell};
            ogds_pkg::REG_RADIUS:    o_prdata = {21'b0, r_rad};
            ogds_pkg::REG_ACT_W:     o_prdata = {24'b0, r_aw};
            ogds_pkg::REG_ACT_H:     o_prdata = {24'b0, r_ah};
            ogds_pkg::REG_OBSTACLE:  o_prdata = {24'b0, r_obst};
            ogds_pkg::REG_FILL:      o_prdata = {24'b0, r_fill};
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_div_sel  = r_div_sel;
        n_step     = r_step;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data = r_out_data;
        n_y        = r_y;
        n_idx      = r_idx;
        n_num      = r_num;
        n_rem      = r_rem;
        n_neg      = r_neg;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_r        = r_r;
        n_r2       = r_r2;
        n_x0       = r_x0;
        n_x1       = r_x1;
        n_y0       = r_y0;
        n_y1       = r_y1;
        n_gx       = r_gx;
        n_gy       = r_gy;
        n_dx0      = r_dx0;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_dx0sq    = r_dx0sq;
        n_dx2      = r_dx2;
        n_dy2      = r_dy2;
        n_row_base = r_row_base;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_ptr      = r_ptr;
        n_res_val  = r_res_val;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = AW'(walk_addr);
        mem_raddr  = AW'(r_idx);
        mem_wdata  = r_obst;
        mul_a      = $signed({4'b0, w_eff});
        mul_b      = $signed({4'b0, h_eff});

        unique case (r_state)
            ogds_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op      = ogds_pkg::t_op'(i_s_axis_tuser);
                    n_y       = $signed(i_s_axis_tdata[31:16]);
                    n_idx     = i_s_axis_tdata[45:32];
                    n_cnt     = 15'd0;
                    n_res_val = 8'd0;
                    unique case (ogds_pkg::t_op'(i_s_axis_tuser))
                        ogds_pkg::OP_CLEAR,
                        ogds_pkg::OP_READ: n_state = ogds_pkg::S_USED;
                        ogds_pkg::OP_MARK: begin
                            n_state   = ogds_pkg::S_DIV;
                            n_div_sel = ogds_pkg::DIV_X;
                            n_step    = 5'd0;
                            n_rem     = 10'd0;
                            n_neg     = diff_x[16];
                            n_num     = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
                        end
                        ogds_pkg::OP_NONE: n_state = ogds_pkg::S_DONE;
                    endcase
                end
            end
            ogds_pkg::S_USED: begin
                n_used  = 16'(mul_p);
                n_ptr   = 16'd0;
                n_state = (r_op == ogds_pkg::OP_CLEAR) ? ogds_pkg::S_CLEAR
                                                       : ogds_pkg::S_RD_ISSUE;
            end
            ogds_pkg::S_CLEAR: begin
                if (r_used == 16'd0) begin
                    n_state = ogds_pkg::S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_ptr);
                    mem_wdata = r_fill;
                    n_ptr     = r_ptr + 16'd1;
                    if (r_ptr == r_used - 16'd1) begin
                        n_cnt   = r_used[14:0];
                        n_state = ogds_pkg::S_DONE;
                    end
                end
            end
            ogds_pkg::S_RD_ISSUE: begin
                if ({2'b0, r_idx} < r_used) begin
                    mem_re  = 1'b1;
                    n_state = ogds_pkg::S_RD_WAIT;
                end else begin
                    n_state = ogds_pkg::S_DONE;
                end
            end
            ogds_pkg::S_RD_WAIT: begin
                n_res_val = r_mem_q;
                n_state   = ogds_pkg::S_DONE;
            end
            ogds_pkg::S_DIV: begin
                if (r_step != ogds_pkg::DIV_STEP_LAST) begin
                    n_rem  = div_rem_next;
                    n_num  = {r_num[14:0], div_ge};
                    n_step = r_step + 5'd1;
                end else begin
                    // quotient done: apply floor for negative offsets, load next
                    n_step = 5'd0;
                    n_rem  = 10'd0;
                    unique case (r_div_sel)
                        ogds_pkg::DIV_X: begin
                            n_cx      = q_signed;
                            n_div_sel = ogds_pkg::DIV_Y;
                            n_neg     = diff_y[16];
                            n_num     = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
                        end
                        ogds_pkg::DIV_Y: begin
                            n_cy      = q_signed;
                            n_div_sel = ogds_pkg::DIV_R;
                            n_neg     = 1'b0;
                            n_num     = {4'b0, ceil_num};
                        end
                        default: begin
                            n_r     = r_num[11:0];
                            n_state = ogds_pkg::S_SQ_R;
                        end
                    endcase
                end
            end
            ogds_pkg::S_SQ_R: begin
                mul_a   = $signed(r_r);
                mul_b   = $signed(r_r);
                n_r2    = 22'(mul_p);
                n_state = ogds_pkg::S_CLIP;
            end
            ogds_pkg::S_CLIP: begin
                n_x0  = x0c[7:0];
                n_x1  = x1c[7:0];
                n_y0  = y0c[7:0];
                n_y1  = y1c[7:0];
                n_dx0 = dx0_full[11:0];
                n_dy  = dy0_full[11:0];
                n_state = clip_empty ? ogds_pkg::S_DONE : ogds_pkg::S_SQ_X;
            end
            ogds_pkg::S_SQ_X: begin
                mul_a   = r_dx0;
                mul_b   = r_dx0;
                n_dx0sq = 22'(mul_p);
                n_state = ogds_pkg::S_SQ_Y;
            end
            ogds_pkg::S_SQ_Y: begin
                mul_a   = r_dy;
                mul_b   = r_dy;
                n_dy2   = 22'(mul_p);
                n_state = ogds_pkg::S_BASE;
            end
            ogds_pkg::S_BASE: begin
                mul_a      = $signed({4'b0, r_y0});
                mul_b      = $signed({4'b0, w_eff});
                n_row_base = 16'(mul_p);
                n_gx       = r_x0;
                n_gy       = r_y0;
                n_dx       = r_dx0;
                n_dx2      = r_dx0sq;
                n_state    = ogds_pkg::S_WALK;
            end
            ogds_pkg::S_WALK: begin
                if (dist2 <= {1'b0, r_r2}) begin
                    mem_we = 1'b1;
                    n_cnt  = r_cnt + 15'd1;
                end
                if (r_gx != r_x1) begin
                    n_gx  = r_gx + 8'd1;
                    n_dx  = r_dx + 12'sd1;
                    n_dx2 = dx2_step[21:0];
                end else if (r_gy != r_y1) begin
                    n_gx       = r_x0;
                    n_dx       = r_dx0;
                    n_dx2      = r_dx0sq;
                    n_gy       = r_gy + 8'd1;
                    n_dy       = r_dy + 12'sd1;
                    n_dy2      = dy2_step[21:0];
                    n_row_base = r_row_base + {8'b0, w_eff};
                end else begin
                    n_state = ogds_pkg::S_DONE;
                end
            end
            ogds_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_cnt, r_res_val};
                    n_state     = ogds_pkg::S_IDLE;
                end
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ogds_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_org_x     <= ogds_pkg::RST_ORIGIN;
            r_org_y     <= ogds_pkg::RST_ORIGIN;
            r_cell      <= ogds_pkg::RST_CELL_SIZE;
            r_rad       <= ogds_pkg::RST_RADIUS;
            r_aw        <= ogds_pkg::RST_ACT_DIM;
            r_ah        <= ogds_pkg::RST_ACT_DIM;
            r_obst      <= ogds_pkg::RST_OBSTACLE;
            r_fill      <= ogds_pkg::RST_FILL;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_psel && i_penable && i_pwrite) begin
                unique case (ogds_pkg::t_reg'(i_paddr[4:2]))
                    ogds_pkg::REG_ORIGIN_X:  r_org_x <= i_pwdata[15:0];
                    ogds_pkg::REG_ORIGIN_Y:  r_org_y <= i_pwdata[15:0];
                    ogds_pkg::REG_CELL_SIZE: r_cell  <= i_pwdata[9:0];
                    ogds_pkg::REG_RADIUS:    r_rad   <= i_pwdata[10:0];
                    ogds_pkg::REG_ACT_W:     r_aw    <= i_pwdata[7:0];
                    ogds_pkg::REG_ACT_H:     r_ah    <= i_pwdata[7:0];
                    ogds_pkg::REG_OBSTACLE:  r_obst  <= i_pwdata[7:0];
                    ogds_pkg::REG_FILL:      r_fill  <= i_pwdata[7:0];
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_div_sel  <= n_div_sel;
        r_step     <= n_step;
        r_out_data <= n_out_data;
        r_y        <= n_y;
        r_idx      <= n_idx;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_r        <= n_r;
        r_r2       <= n_r2;
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_y0       <= n_y0;
        r_y1       <= n_y1;
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_dx0      <= n_dx0;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dx0sq    <= n_dx0sq;
        r_dx2      <= n_dx2;
        r_dy2      <= n_dy2;
        r_row_base <= n_row_base;
        r_cnt      <= n_cnt;
        r_used     <= n_used;
        r_ptr      <= n_ptr;
        r_res_val  <= n_res_val;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while a request is in progress");

    a_div_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogds_pkg::S_DIV) |-> (r_step <= ogds_pkg::DIV_STEP_LAST))
        else $error("divider step counter overran");

    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogds_pkg::S_WALK) |-> (r_gx <= r_x1 && r_gy <= r_y1
                                           && r_gx >= r_x0 && r_gy >= r_y0))
        else $error("walk left the clipped window");

    a_dx_tracks_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogds_pkg::S_WALK) |->
        (($signed({11'b0, r_gx}) - $signed({r_cx[17], r_cx}))
         == $signed({{7{r_dx[11]}}, r_dx})))
        else $error("column offset out of step with column");
`endif

endmodule
